[rtl/core/isbn13v_pkg.sv]
// shared types, constants and helper functions of the isbn-13 validator
`default_nettype none
package isbn13v_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned HyphenW = 3;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned SumW    = 4;

  localparam logic [PosW-1:0]    PosMax       = 5'd31;
  localparam logic [HyphenW-1:0] HyphenMax    = 3'd7;
  localparam logic [DigitW-1:0]  DigitMax     = 4'd15;
  localparam logic [PosW-1:0]    IsbnLen      = 5'd17;
  localparam logic [HyphenW-1:0] HyphensNeed  = 3'd4;
  localparam logic [PosW-1:0]    CheckPos     = 5'd16;
  localparam logic [PosW-1:0]    PrefixLen    = 5'd4;
  localparam logic [DigitW-1:0]  SummedDigits = 4'd12;

  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChSeven   = 8'h37;
  localparam logic [CharW-1:0] ChEight   = 8'h38;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChHyphen  = 8'h2d;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChNewline = 8'h0a;

  typedef struct packed {
    logic             fire;
    logic [CharW-1:0] ch;
    logic             last;
  } step_t;

  typedef struct packed {
    logic emit;
    logic ok;
  } res_t;

  function automatic logic prefix_ok(input logic [1:0] pos, input logic [CharW-1:0] ch);
    logic r;
    unique case (pos)
      2'd0:    r = (ch == ChNine);
      2'd1:    r = (ch == ChSeven);
      2'd2:    r = (ch == ChEight) || (ch == ChNine);
      default: r = (ch == ChHyphen);
    endcase
    return r;
  endfunction

  // value is at most 36
  function automatic logic [SumW-1:0] mod10(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd30) begin
      r = v - 6'd30;
    end else if (v >= 6'd20) begin
      r = v - 6'd20;
    end else if (v >= 6'd10) begin
      r = v - 6'd10;
    end else begin
      r = v;
    end
    return r[SumW-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/isbn13v_accum.sv]
// per-string state registers, next-state logic and verdict for one character
`default_nettype none
module isbn13v_accum (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire isbn13v_pkg::step_t   step,
  output isbn13v_pkg::res_t         res
);

  logic [isbn13v_pkg::PosW-1:0]    pos_r, pos_nxt;
  logic [isbn13v_pkg::HyphenW-1:0] hy_r, hy_nxt;
  logic [isbn13v_pkg::DigitW-1:0]  dc_r, dc_nxt, dc_inc;
  logic [isbn13v_pkg::SumW-1:0]    sum_r, sum_nxt, cd;
  logic                            bad_r, bad_nxt;
  logic [isbn13v_pkg::CharW-1:0]   chk_r, chk_nxt;
  logic                            is_digit, is_hyphen, is_blank;
  logic [3:0]                      d;
  logic [4:0]                      dw;

  always_comb begin
    is_digit  = (step.ch >= isbn13v_pkg::ChZero) && (step.ch <= isbn13v_pkg::ChNine);
    is_hyphen = (step.ch == isbn13v_pkg::ChHyphen);
    is_blank  = (step.ch == isbn13v_pkg::ChSpace) || (step.ch == isbn13v_pkg::ChNewline);
    d         = step.ch[3:0];

    hy_nxt = (is_hyphen && hy_r != isbn13v_pkg::HyphenMax) ? hy_r + 3'd1 : hy_r;
    dc_inc = (dc_r != isbn13v_pkg::DigitMax) ? dc_r + 4'd1 : dc_r;
    dc_nxt = is_digit ? dc_inc : dc_r;

    // weight 1 on odd digit counts, 3 on even ones
    dw = dc_inc[0] ? {1'b0, d} : ({1'b0, d} + {d, 1'b0});
    if (is_digit && dc_inc <= isbn13v_pkg::SummedDigits) begin
      sum_nxt = isbn13v_pkg::mod10({2'b00, sum_r} + {1'b0, dw});
    end else begin
      sum_nxt = sum_r;
    end

    bad_nxt = bad_r;
    if (!is_digit && !is_hyphen && !is_blank) begin
      bad_nxt = 1'b1;
    end
    if (pos_r < isbn13v_pkg::PrefixLen && !isbn13v_pkg::prefix_ok(pos_r[1:0], step.ch)) begin
      bad_nxt = 1'b1;
    end

    chk_nxt = (pos_r == isbn13v_pkg::CheckPos) ? step.ch : chk_r;
    pos_nxt = (pos_r != isbn13v_pkg::PosMax) ? pos_r + 5'd1 : pos_r;

    cd = (sum_nxt == 4'd0) ? 4'd0 : 4'd10 - sum_nxt;

    res.emit = step.fire && step.last;
    res.ok   = !bad_nxt
            && (pos_nxt == isbn13v_pkg::IsbnLen)
            && (hy_nxt == isbn13v_pkg::HyphensNeed)
            && (chk_nxt == isbn13v_pkg::ChZero + {4'd0, cd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hy_r  <= '0;
      dc_r  <= '0;
      sum_r <= '0;
      bad_r <= 1'b0;
      chk_r <= '0;
    end else if (step.fire) begin
      if (step.last) begin
        pos_r <= '0;
        hy_r  <= '0;
        dc_r  <= '0;
        sum_r <= '0;
        bad_r <= 1'b0;
        chk_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        hy_r  <= hy_nxt;
        dc_r  <= dc_nxt;
        sum_r <= sum_nxt;
        bad_r <= bad_nxt;
        chk_r <= chk_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/isbn13_hyphenated_validator_top.sv]
// top level of the hyphenated isbn-13 validator: input register, accumulator, result register
// One character is taken per request, one per cycle sustained; the character flagged as last
// yields one result request carrying valid_res, presented on the output once the character
// has passed the input register and the accumulator into the result register, and every
// other character yields none. The accumulator update is combinational; a pending
// result stalls only a last character, and further input waits behind it.
`default_nettype none
module isbn13_hyphenated_validator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [isbn13v_pkg::CharW-1:0] in_character,
  input  wire logic                          in_is_last,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          out_valid_res
);

  logic                          s1_valid_r;
  logic [isbn13v_pkg::CharW-1:0] s1_ch_r;
  logic                          s1_last_r;
  logic                          advance;
  logic                          out_valid_r;
  logic                          out_res_r;
  isbn13v_pkg::step_t            step;
  isbn13v_pkg::res_t             res;

  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign step.fire = advance;
  assign step.ch   = s1_ch_r;
  assign step.last = s1_last_r;

  isbn13v_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r   <= in_character;
      s1_last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_res_r <= res.ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule
`default_nettype wire

[rtl/core/isbn13v_checker.sv]
// port-level assertions for the isbn-13 validator top level, with bind
`default_nettype none
module isbn13v_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_is_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_valid_res
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res))
    else $error("result changed while stalled");

  // a new result comes from a last character taken earlier
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2))
    else $error("result without a last character");

  // a non-last character never produces a result
  a_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_is_last) ##1 !out_valid |=> !out_valid)
    else $error("result from a non-last character");

  // with no pending result the input side is never blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind isbn13_hyphenated_validator_top isbn13v_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_is_last    (in_is_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_valid_res (out_valid_res)
);
`default_nettype wire
